// ===== rtl/lts_pkg.sv =====
// Shared types, token codes and keyword table of the Lua token scanner.
package lts_pkg;

    // Default widths of the position and line/column counters.
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int KEYWORD_MAX_CHARS = 8;
    localparam int KW_COUNT = 21;

    // Fixed widths of the result fields.
    localparam int CODE_W = 6;
    localparam int OUT_OFF_W = 24;
    localparam int OUT_LINE_W = 16;

    // Depth of the result queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_TOKENS = 3;

    // Token codes.
    localparam logic [CODE_W-1:0] TOK_EOF     = 6'd0;
    localparam logic [CODE_W-1:0] TOK_LPAREN  = 6'd1;
    localparam logic [CODE_W-1:0] TOK_RPAREN  = 6'd2;
    localparam logic [CODE_W-1:0] TOK_LBRACE  = 6'd3;
    localparam logic [CODE_W-1:0] TOK_RBRACE  = 6'd4;
    localparam logic [CODE_W-1:0] TOK_COMMA   = 6'd5;
    localparam logic [CODE_W-1:0] TOK_DOT     = 6'd6;
    localparam logic [CODE_W-1:0] TOK_MINUS   = 6'd7;
    localparam logic [CODE_W-1:0] TOK_PLUS    = 6'd8;
    localparam logic [CODE_W-1:0] TOK_SEMI    = 6'd9;
    localparam logic [CODE_W-1:0] TOK_STAR    = 6'd10;
    localparam logic [CODE_W-1:0] TOK_NE      = 6'd11;
    localparam logic [CODE_W-1:0] TOK_BANG    = 6'd12;
    localparam logic [CODE_W-1:0] TOK_EQEQ    = 6'd13;
    localparam logic [CODE_W-1:0] TOK_ASSIGN  = 6'd14;
    localparam logic [CODE_W-1:0] TOK_LE      = 6'd15;
    localparam logic [CODE_W-1:0] TOK_LT      = 6'd16;
    localparam logic [CODE_W-1:0] TOK_GE      = 6'd17;
    localparam logic [CODE_W-1:0] TOK_GT      = 6'd18;
    localparam logic [CODE_W-1:0] TOK_SLASH   = 6'd19;
    localparam logic [CODE_W-1:0] TOK_STRING  = 6'd20;
    localparam logic [CODE_W-1:0] TOK_NUMBER  = 6'd21;
    localparam logic [CODE_W-1:0] TOK_IDENT   = 6'd22;
    localparam logic [CODE_W-1:0] TOK_KW0     = 6'd23;
    localparam logic [CODE_W-1:0] TOK_BAD     = 6'd44;
    localparam logic [CODE_W-1:0] TOK_UNTERM  = 6'd45;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Keywords, right aligned so that the last character sits in the low byte.
    localparam logic [8*KEYWORD_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "if", "in", "local", "nil", "not", "or", "repeat",
        "return", "then", "true", "until", "while"
    };

    // One result token.
    typedef struct packed {
        logic [CODE_W-1:0]     code;
        logic [OUT_OFF_W-1:0]  start;
        logic [OUT_OFF_W-1:0]  len;
        logic [OUT_LINE_W-1:0] line;
        logic [OUT_LINE_W-1:0] col;
        logic                  last;
    } t_token;

    // All tokens caused by one input item.
    typedef struct packed {
        logic [1:0]                  count;
        t_token [MAX_TOKENS-1:0]     tok;
    } t_bundle;

    // Identifier or keyword code for a collected word.
    function automatic logic [CODE_W-1:0] f_ident_code(
        input logic [8*KEYWORD_MAX_CHARS-1:0] kbuf,
        input logic [3:0] wlen
    );
        logic [CODE_W-1:0] code;
        code = TOK_IDENT;
        if (wlen <= 4'(KEYWORD_MAX_CHARS)) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (kbuf == KW_TEXT[k]) begin
                    code = TOK_KW0 + CODE_W'(k);
                end
            end
        end
        return code;
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
    endfunction

endpackage

// ===== rtl/lts_if.sv =====
// Stream interfaces for source items and result tokens.
interface lts_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface lts_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_code;
    logic [23:0] start_offset;
    logic [23:0] text_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;

    modport source (output valid, output token_code, output start_offset,
                    output text_length, output line_number, output column_number,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_code, input start_offset,
                    input text_length, input line_number, input column_number,
                    input last_of_run, output ready);
endinterface

// ===== rtl/lts_front.sv =====
// Front part: scans one source item per cycle while the queue has space and builds its token bundle.
module lts_front
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_kind,
    input  logic [7:0] i_byte,
    input  logic    i_space,
    output logic    o_ready,
    output logic    o_push,
    output t_bundle o_bundle
);

    typedef enum logic [3:0] {
        M_IDLE, M_MINUS, M_COMMENT, M_BANG, M_EQ, M_LESS, M_GREATER,
        M_STRING, M_NUMBER, M_NUMDOT, M_FRACTION, M_IDENT
    } t_mode;

    localparam logic [LINE_BITS-1:0] LC_MAX = '1;
    localparam logic [LINE_BITS-1:0] LC_ONE = LINE_BITS'(1);

    t_mode r_mode, n_mode;
    logic [8*KEYWORD_MAX_CHARS-1:0] r_kbuf, n_kbuf;
    logic [3:0] r_wlen, n_wlen;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_ts, n_ts;
    logic [LINE_BITS-1:0] r_line, n_line, r_col, n_col;

    t_bundle n_bundle;
    logic    take;
    logic    cont;
    logic [OFFSET_BITS-1:0] p;
    logic [CODE_W-1:0] op_code;

    // Token built from the working counters.
    function automatic t_token f_tok(
        input logic [CODE_W-1:0] code,
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] len,
        input logic [LINE_BITS-1:0] line,
        input logic [LINE_BITS-1:0] col
    );
        t_token t;
        t.code  = code;
        t.start = OUT_OFF_W'(start);
        t.len   = OUT_OFF_W'(len);
        t.line  = OUT_LINE_W'(line);
        t.col   = OUT_LINE_W'(col);
        t.last  = 1'b0;
        return t;
    endfunction

    assign o_ready = i_space;
    assign take    = i_valid & i_space;

    // Scanner step: extend the pending token with the byte, or flush it and then dispatch the byte or end item.
    always_comb begin
        n_mode = r_mode;
        n_kbuf = r_kbuf;
        n_wlen = r_wlen;
        n_pos  = r_pos;
        n_ts   = r_ts;
        n_line = r_line;
        n_col  = r_col;
        n_bundle = '0;
        cont = 1'b0;
        p = '0;
        op_code = TOK_GT;

        unique case (r_mode)
            M_BANG:  op_code = TOK_BANG;
            M_EQ:    op_code = TOK_ASSIGN;
            M_LESS:  op_code = TOK_LT;
            default: op_code = TOK_GT;
        endcase

        // Tokens that continue with this byte.
        if (i_kind == KIND_BYTE) begin
            unique case (r_mode)
                M_MINUS: begin
                    if (i_byte == "-") begin
                        n_mode = M_COMMENT;
                        cont = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_byte != 8'h0A) begin
                        cont = 1'b1;
                    end
                end
                M_BANG, M_EQ, M_LESS, M_GREATER: begin
                    if (i_byte == "=") begin
                        n_pos = r_pos + 1'b1;
                        n_col = (r_col != LC_MAX) ? r_col + 1'b1 : r_col;
                        n_bundle.tok[0] = f_tok(op_code - 1'b1, r_ts, n_pos - r_ts,
                                                n_line, n_col);
                        n_bundle.count = 2'd1;
                        n_mode = M_IDLE;
                        cont = 1'b1;
                    end
                end
                M_STRING: begin
                    cont = 1'b1;
                end
                M_NUMBER: begin
                    if (f_is_digit(i_byte)) begin
                        cont = 1'b1;
                    end else if (i_byte == ".") begin
                        n_mode = M_NUMDOT;
                        cont = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (f_is_digit(i_byte)) begin
                        n_col = (r_col != LC_MAX) ? r_col + 1'b1 : r_col;
                        n_mode = M_FRACTION;
                        cont = 1'b1;
                    end
                end
                M_FRACTION: begin
                    if (f_is_digit(i_byte)) begin
                        cont = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (f_is_alpha(i_byte) || f_is_digit(i_byte)) begin
                        if (r_wlen < 4'(KEYWORD_MAX_CHARS)) begin
                            n_kbuf = {r_kbuf[8*KEYWORD_MAX_CHARS-9:0], i_byte};
                        end
                        if (r_wlen <= 4'(KEYWORD_MAX_CHARS)) begin
                            n_wlen = r_wlen + 1'b1;
                        end
                        cont = 1'b1;
                    end
                end
                default: cont = 1'b0;
            endcase

            // Ordinary absorb of a continuing byte; the held dot skips the column.
            if (cont && !(r_mode inside {M_BANG, M_EQ, M_LESS, M_GREATER})) begin
                n_pos = n_pos + 1'b1;
                if (!(r_mode == M_NUMBER && i_byte == ".")) begin
                    if (i_byte == 8'h0A) begin
                        n_line = (n_line != LC_MAX) ? n_line + 1'b1 : n_line;
                        n_col  = LC_ONE;
                    end else begin
                        n_col = (n_col != LC_MAX) ? n_col + 1'b1 : n_col;
                    end
                end
                if (r_mode == M_STRING && i_byte == "\"") begin
                    n_bundle.tok[0] = f_tok(TOK_STRING, r_ts + 1'b1,
                                            OFFSET_BITS'(n_pos - r_ts - 2'd2), n_line, n_col);
                    n_bundle.count = 2'd1;
                    n_mode = M_IDLE;
                end
            end
        end

        // Flush whatever token is pending.
        if (!cont) begin
            unique case (r_mode)
                M_MINUS: begin
                    n_bundle.tok[0] = f_tok(TOK_MINUS, r_ts, r_pos - r_ts, r_line, r_col);
                    n_bundle.count = 2'd1;
                end
                M_BANG, M_EQ, M_LESS, M_GREATER: begin
                    n_bundle.tok[0] = f_tok(op_code, r_ts, r_pos - r_ts, r_line, r_col);
                    n_bundle.count = 2'd1;
                end
                M_NUMBER, M_FRACTION: begin
                    n_bundle.tok[0] = f_tok(TOK_NUMBER, r_ts, r_pos - r_ts, r_line, r_col);
                    n_bundle.count = 2'd1;
                end
                M_NUMDOT: begin
                    n_bundle.tok[0] = f_tok(TOK_NUMBER, r_ts,
                                            OFFSET_BITS'(r_pos - 1'b1 - r_ts), r_line, r_col);
                    n_col = (r_col != LC_MAX) ? r_col + 1'b1 : r_col;
                    n_bundle.tok[1] = f_tok(TOK_DOT, r_pos - 1'b1,
                                            OFFSET_BITS'(1), r_line, n_col);
                    n_bundle.count = 2'd2;
                end
                M_IDENT: begin
                    n_bundle.tok[0] = f_tok(f_ident_code(r_kbuf, r_wlen), r_ts,
                                            r_pos - r_ts, r_line, r_col);
                    n_bundle.count = 2'd1;
                end
                M_STRING: begin
                    n_bundle.tok[0] = f_tok(TOK_UNTERM, r_ts + 1'b1,
                                            OFFSET_BITS'(r_pos - r_ts - 1'b1), r_line, r_col);
                    n_bundle.count = 2'd1;
                end
                default: n_bundle.count = 2'd0;
            endcase
            n_mode = M_IDLE;

            if (i_kind == KIND_END) begin
                // End of source: report EOF and return to the reset state.
                n_bundle.tok[n_bundle.count] = f_tok(TOK_EOF, r_pos, '0, r_line, n_col);
                n_bundle.count = n_bundle.count + 1'b1;
                n_kbuf = '0;
                n_wlen = '0;
                n_pos  = '0;
                n_ts   = '0;
                n_line = LC_ONE;
                n_col  = LC_ONE;
            end else begin
                // Dispatch the byte from idle.
                p = r_pos;
                n_ts = r_pos;
                n_pos = r_pos + 1'b1;
                if (i_byte == 8'h0A) begin
                    n_line = (n_line != LC_MAX) ? n_line + 1'b1 : n_line;
                    n_col  = LC_ONE;
                end else begin
                    n_col = (n_col != LC_MAX) ? n_col + 1'b1 : n_col;
                end
                case (i_byte)
                    "(", ")", "{", "}", ",", ".", "+", ";", "*", "/": begin
                        case (i_byte)
                            "(":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_LPAREN, p, OFFSET_BITS'(1), n_line, n_col);
                            ")":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_RPAREN, p, OFFSET_BITS'(1), n_line, n_col);
                            "{":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_LBRACE, p, OFFSET_BITS'(1), n_line, n_col);
                            "}":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_RBRACE, p, OFFSET_BITS'(1), n_line, n_col);
                            ",":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_COMMA, p, OFFSET_BITS'(1), n_line, n_col);
                            ".":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_DOT, p, OFFSET_BITS'(1), n_line, n_col);
                            "+":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_PLUS, p, OFFSET_BITS'(1), n_line, n_col);
                            ";":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_SEMI, p, OFFSET_BITS'(1), n_line, n_col);
                            "*":     n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_STAR, p, OFFSET_BITS'(1), n_line, n_col);
                            default: n_bundle.tok[n_bundle.count] =
                                         f_tok(TOK_SLASH, p, OFFSET_BITS'(1), n_line, n_col);
                        endcase
                        n_bundle.count = n_bundle.count + 1'b1;
                    end
                    "-":  n_mode = M_MINUS;
                    "!":  n_mode = M_BANG;
                    "=":  n_mode = M_EQ;
                    "<":  n_mode = M_LESS;
                    ">":  n_mode = M_GREATER;
                    "\"": n_mode = M_STRING;
                    " ", 8'h0D, 8'h09, 8'h0A: n_mode = M_IDLE;
                    default: begin
                        if (f_is_digit(i_byte)) begin
                            n_mode = M_NUMBER;
                        end else if (f_is_alpha(i_byte)) begin
                            n_mode = M_IDENT;
                            n_kbuf = {{(8*KEYWORD_MAX_CHARS-8){1'b0}}, i_byte};
                            n_wlen = 4'd1;
                        end else begin
                            n_bundle.tok[n_bundle.count] =
                                f_tok(TOK_BAD, p, OFFSET_BITS'(1), n_line, n_col);
                            n_bundle.count = n_bundle.count + 1'b1;
                        end
                    end
                endcase
            end
        end

        // Mark the final token of this item.
        if (n_bundle.count != 2'd0) begin
            n_bundle.tok[n_bundle.count - 1'b1].last = 1'b1;
        end
    end

    // Scanner state; the bundle goes to the queue combinationally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_kbuf <= '0;
            r_wlen <= '0;
            r_pos  <= '0;
            r_ts   <= '0;
            r_line <= LC_ONE;
            r_col  <= LC_ONE;
        end else if (take) begin
            r_mode <= n_mode;
            r_kbuf <= n_kbuf;
            r_wlen <= n_wlen;
            r_pos  <= n_pos;
            r_ts   <= n_ts;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    assign o_push   = take && (n_bundle.count != 2'd0);
    assign o_bundle = n_bundle;

endmodule

// ===== rtl/lts_queue.sv =====
// Short queue of token bundles between the front and the back part.
module lts_queue
    import lts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_space,
    output logic    o_valid,
    output t_bundle o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_space = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_store[r_rd];

    // Pointer wrap at the queue depth.
    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr] <= i_bundle;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The front never writes into a full queue, and the back never pops an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

endmodule

// ===== rtl/lts_back.sv =====
// Back part: hands the tokens of each bundle out one transfer at a time.
module lts_back
    import lts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_bundle i_head,
    input  logic    i_ready,
    output logic    o_pop,
    output logic    o_valid,
    output t_token  o_token
);

    logic [1:0] r_idx;
    logic       xfer;
    logic       at_last;

    assign o_valid = i_valid;
    assign o_token = i_head.tok[r_idx];
    assign xfer    = i_valid & i_ready;
    assign at_last = (r_idx == i_head.count - 1'b1);
    assign o_pop   = xfer & at_last;

    // Token index within the head bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= at_last ? 2'd0 : r_idx + 1'b1;
        end
    end

    // Index stays inside the bundle, and the last flag marks the bundle's end.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx < i_head.count))
        else $error("token index beyond bundle");
    a_last_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |-> (o_token.last == at_last))
        else $error("last flag does not match bundle end");

endmodule

// ===== rtl/lua_token_scanner_unit.sv =====
// Top level of the Lua token scanner: front scanner, bundle queue and token output.
//
// Usage: source bytes arrive on i_src, one transfer per byte with kind set to
// byte, and a source ends with one transfer of kind end. Tokens leave on o_tok
// as code, start offset, length, line and column; last_of_run marks the final
// token caused by one input transfer.
// The front scans one input item per cycle while the queue has space and writes
// all its tokens (zero to three) as one bundle into a two-entry queue. The back
// sends one token per cycle from the head bundle while the receiver is ready.
// A token's bundle is registered in the queue, and the token leaves o_tok from
// the queue head. Throughput: one input item per cycle while each item causes at
// most one token and the receiver does not stall; an item that causes several
// tokens occupies the single output port with one transfer per token.
// Reset clears the scanner to line 1, column 1, offset 0 and empties the
// queue. An end item also returns the scanner to that state after EOF.
// When the receiver stalls, the queue fills and i_src.ready drops once both
// entries are held; no token is lost or repeated.
module lua_token_scanner_unit
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lts_in_if.sink     i_src,
    lts_tok_if.source  o_tok
);

    logic    space;
    logic    push;
    logic    pop;
    logic    head_valid;
    t_bundle bundle;
    t_bundle head;
    t_token  token;

    lts_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_src.valid),
        .i_kind   (i_src.kind),
        .i_byte   (i_src.byte_value),
        .i_space  (space),
        .o_ready  (i_src.ready),
        .o_push   (push),
        .o_bundle (bundle)
    );

    lts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_space  (space),
        .o_valid  (head_valid),
        .o_head   (head)
    );

    lts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head),
        .i_ready (o_tok.ready),
        .o_pop   (pop),
        .o_valid (o_tok.valid),
        .o_token (token)
    );

    // Result fields.
    assign o_tok.token_code    = token.code;
    assign o_tok.start_offset  = token.start;
    assign o_tok.text_length   = token.len;
    assign o_tok.line_number   = token.line;
    assign o_tok.column_number = token.col;
    assign o_tok.last_of_run   = token.last;

endmodule
